// File: design/impq_pkg.sv
// package for the indexed max priority queue
// types, constants and the ordering function shared by the compare unit and the top level
`timescale 1ns / 1ps

package impq_pkg;

    localparam int CAPACITY   = 256;
    localparam int SLOT_W     = $clog2(CAPACITY + 1);
    localparam int ID_W       = 8;
    localparam int HANDLES    = 1 << ID_W;
    localparam int LEVEL_W    = 7;
    localparam int STAMP_W    = 32;
    localparam int ENTRY_W    = ID_W + LEVEL_W + STAMP_W;
    localparam logic [LEVEL_W-1:0] CEILING_RESET = 7'd100;

    typedef enum logic [1:0] {
        ACT_INSERT = 2'd0,
        ACT_RAISE  = 2'd1,
        ACT_REMOVE = 2'd2,
        ACT_QUERY  = 2'd3
    } action_t;

    typedef struct packed {
        logic [ID_W-1:0]    id;
        logic [LEVEL_W-1:0] level;
        logic [STAMP_W-1:0] arrival;
    } entry_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_POS_RD,
        ST_POS_WAIT,
        ST_DECIDE,
        ST_LAST_RD,
        ST_LAST_WAIT,
        ST_ENTRY_RD,
        ST_ENTRY_WAIT,
        ST_PLACE,
        ST_UP_RD,
        ST_UP_WAIT,
        ST_UP_CMP,
        ST_DN_RDL,
        ST_DN_CMPL,
        ST_DN_CMPR,
        ST_DN_STEP,
        ST_DN_MOVE,
        ST_DONE,
        ST_CLEAR
    } state_t;

    // true when a ranks above b: higher level, or equal level and earlier stamp
    function automatic logic outranks(input entry_t a, input entry_t b);
        logic r;
        if (a.level != b.level)
            r = a.level > b.level;
        else
            r = a.arrival < b.arrival;
        return r;
    endfunction

endpackage

// File: design/impq_ram.sv
// generic single port ram with registered read
// no dependencies
`timescale 1ns / 1ps

module impq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
            mem[addr] <= wdata;
        rdata <= mem[addr];
    end

endmodule

// File: design/impq_cmp.sv
// shared compare unit: picks the better of two heap entries
// depends on impq_pkg
`timescale 1ns / 1ps

module impq_cmp
    import impq_pkg::*;
(
    input  entry_t a,
    input  entry_t b,
    output logic   a_wins
);

    assign a_wins = outranks(a, b);

endmodule

// File: design/indexed_max_priority_queue.sv
// indexed max priority queue top level; uses impq_pkg, impq_ram, impq_cmp
// query: result_valid strobes after the map and root reads; busy until back in idle
// insert/raise/remove: an ignored item or removal of the last slot finishes after
// the decide state, else the item sifts up, then down (capacity 256 entries)
// one item at a time, the next is taken while busy is low; the receiver cannot
// stall; reset: a pass over all 256 map entries clears the slot map, busy high
`timescale 1ns / 1ps

module indexed_max_priority_queue
    import impq_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [1:0]         action,
    input  logic [ID_W-1:0]    entry_id,
    input  logic [LEVEL_W-1:0] level_value,
    input  logic               cfg_we,
    input  logic [LEVEL_W-1:0] cfg_wdata,
    output logic               result_valid,
    output logic               heap_empty,
    output logic [ID_W-1:0]    top_id
);

    state_t state_reg, state_next;
    logic [1:0]         act_reg, act_next;
    logic [ID_W-1:0]    id_reg, id_next;
    logic [LEVEL_W-1:0] lv_reg, lv_next;
    logic [LEVEL_W-1:0] ceil_reg;
    logic [SLOT_W-1:0]  count_reg, count_next;
    logic [STAMP_W-1:0] stamp_reg, stamp_next;
    logic [SLOT_W-1:0]  cur_reg, cur_next;
    logic [SLOT_W-1:0]  best_reg, best_next;
    entry_t             cur_e_reg, cur_e_next;
    entry_t             best_e_reg, best_e_next;
    logic               res_reg, res_next;
    logic               emp_reg, emp_next;
    logic [ID_W-1:0]    top_reg, top_next;
    logic [ID_W-1:0]    clr_reg, clr_next;

    // heap memory, slots 0..CAPACITY (slot 0 unused)
    logic                   h_we;
    logic [SLOT_W-1:0]      h_addr;
    entry_t                 h_wdata;
    logic [ENTRY_W-1:0]     h_rdata;
    entry_t                 h_rd;

    // slot map memory
    logic                   p_we;
    logic [ID_W-1:0]        p_addr;
    logic [SLOT_W-1:0]      p_wdata, p_rdata;
    logic [SLOT_W-1:0]      pos_reg, pos_next;

    impq_ram #(.WIDTH(ENTRY_W), .DEPTH(1 << SLOT_W)) u_heap (
        .clk(clk), .we(h_we), .addr(h_addr), .wdata(h_wdata), .rdata(h_rdata)
    );

    impq_ram #(.WIDTH(SLOT_W), .DEPTH(HANDLES)) u_pos (
        .clk(clk), .we(p_we), .addr(p_addr), .wdata(p_wdata), .rdata(p_rdata)
    );

    assign h_rd = entry_t'(h_rdata);

    entry_t cmp_a, cmp_b;
    logic   a_wins;

    impq_cmp u_cmp (.a(cmp_a), .b(cmp_b), .a_wins(a_wins));

    logic [LEVEL_W:0] raised;
    assign raised = {1'b0, cur_e_reg.level} + {1'b0, lv_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            ceil_reg  <= CEILING_RESET;
            count_reg <= '0;
            stamp_reg <= '0;
            res_reg   <= 1'b0;
            clr_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
                ceil_reg <= cfg_wdata;
            count_reg <= count_next;
            stamp_reg <= stamp_next;
            res_reg   <= res_next;
            clr_reg   <= clr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        act_reg    <= act_next;
        id_reg     <= id_next;
        lv_reg     <= lv_next;
        cur_reg    <= cur_next;
        best_reg   <= best_next;
        cur_e_reg  <= cur_e_next;
        best_e_reg <= best_e_next;
        emp_reg    <= emp_next;
        top_reg    <= top_next;
        pos_reg    <= pos_next;
    end

    always_comb
    begin
        state_next  = state_reg;
        act_next    = act_reg;
        id_next     = id_reg;
        lv_next     = lv_reg;
        count_next  = count_reg;
        stamp_next  = stamp_reg;
        cur_next    = cur_reg;
        best_next   = best_reg;
        cur_e_next  = cur_e_reg;
        best_e_next = best_e_reg;
        res_next    = 1'b0;
        emp_next    = emp_reg;
        top_next    = top_reg;
        clr_next    = clr_reg;
        pos_next    = pos_reg;
        h_we        = 1'b0;
        h_addr      = cur_reg;
        h_wdata     = cur_e_reg;
        p_we        = 1'b0;
        p_addr      = id_reg;
        p_wdata     = '0;
        cmp_a       = cur_e_reg;
        cmp_b       = h_rd;
        unique case (state_reg)
            ST_CLEAR:
            begin
                p_we     = 1'b1;
                p_addr   = clr_reg;
                clr_next = clr_reg + 1'b1;
                if (clr_reg == ID_W'(HANDLES - 1))
                    state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                if (start)
                begin
                    act_next   = action;
                    id_next    = entry_id;
                    lv_next    = level_value;
                    state_next = ST_POS_RD;
                end
            end
            ST_POS_RD:
            begin
                // address the map and the root together
                h_addr     = SLOT_W'(1);
                state_next = ST_POS_WAIT;
            end
            ST_POS_WAIT:
            begin
                pos_next   = p_rdata;
                top_next   = h_rd.id;
                state_next = ST_DECIDE;
            end
            ST_DECIDE:
            begin
                state_next = ST_DONE;
                unique case (action_t'(act_reg))
                    ACT_QUERY:
                    begin
                        res_next = 1'b1;
                        emp_next = (count_reg == '0);
                        if (count_reg == '0)
                            top_next = '0;
                    end
                    ACT_INSERT:
                    begin
                        if (pos_reg == '0 && count_reg < SLOT_W'(CAPACITY))
                        begin
                            stamp_next         = stamp_reg + 1'b1;
                            count_next         = count_reg + 1'b1;
                            cur_next           = count_reg + 1'b1;
                            cur_e_next.id      = id_reg;
                            cur_e_next.level   = (lv_reg > ceil_reg) ? ceil_reg : lv_reg;
                            cur_e_next.arrival = stamp_reg + 1'b1;
                            state_next         = ST_PLACE;
                        end
                    end
                    ACT_RAISE:
                    begin
                        if (pos_reg != '0 && pos_reg <= count_reg)
                        begin
                            cur_next   = pos_reg;
                            state_next = ST_ENTRY_RD;
                        end
                    end
                    ACT_REMOVE:
                    begin
                        if (pos_reg != '0 && pos_reg <= count_reg)
                        begin
                            p_we       = 1'b1;
                            cur_next   = pos_reg;
                            count_next = count_reg - 1'b1;
                            if (pos_reg != count_reg)
                                state_next = ST_LAST_RD;
                        end
                    end
                    default: ;
                endcase
            end
            ST_LAST_RD:
            begin
                // old last slot is count_reg + 1 now
                h_addr     = count_reg + 1'b1;
                state_next = ST_LAST_WAIT;
            end
            ST_LAST_WAIT:
            begin
                cur_e_next = h_rd;
                state_next = ST_PLACE;
            end
            ST_ENTRY_RD:
            begin
                state_next = ST_ENTRY_WAIT;
            end
            ST_ENTRY_WAIT:
            begin
                cur_e_next = h_rd;
                state_next = ST_PLACE;
            end
            ST_PLACE:
            begin
                if (action_t'(act_reg) == ACT_RAISE)
                    cur_e_next.level = (raised > {1'b0, ceil_reg}) ? ceil_reg
                                                                  : raised[LEVEL_W-1:0];
                state_next = ST_UP_RD;
            end
            ST_UP_RD:
            begin
                // cur_e_reg is held, not yet written to cur slot
                if (cur_reg == SLOT_W'(1))
                    state_next = ST_DN_RDL;
                else
                begin
                    h_addr     = cur_reg >> 1;
                    state_next = ST_UP_WAIT;
                end
            end
            ST_UP_WAIT:
            begin
                state_next = ST_UP_CMP;
                best_e_next = h_rd;
            end
            ST_UP_CMP:
            begin
                cmp_b = best_e_reg;
                if (a_wins)
                begin
                    // parent moves down into cur
                    h_we      = 1'b1;
                    h_addr    = cur_reg;
                    h_wdata   = best_e_reg;
                    p_we      = 1'b1;
                    p_addr    = best_e_reg.id;
                    p_wdata   = cur_reg;
                    cur_next  = cur_reg >> 1;
                    state_next = ST_UP_RD;
                end
                else
                    state_next = ST_DN_RDL;
            end
            ST_DN_RDL:
            begin
                best_next = cur_reg;
                if ({cur_reg, 1'b0} <= {1'b0, count_reg})
                begin
                    h_addr     = {cur_reg[SLOT_W-2:0], 1'b0};
                    state_next = ST_DN_CMPL;
                end
                else
                    state_next = ST_DN_MOVE;
            end
            ST_DN_CMPL:
            begin
                // left child data is present now; address the right child
                h_addr      = {cur_reg[SLOT_W-2:0], 1'b1};
                best_e_next = cur_e_reg;
                cmp_a       = h_rd;
                cmp_b       = cur_e_reg;
                if (a_wins)
                begin
                    best_e_next = h_rd;
                    best_next   = {cur_reg[SLOT_W-2:0], 1'b0};
                end
                state_next = ST_DN_CMPR;
            end
            ST_DN_CMPR:
            begin
                // right child data present now
                cmp_a = h_rd;
                cmp_b = best_e_reg;
                if ({cur_reg, 1'b1} <= {1'b0, count_reg} && a_wins)
                begin
                    best_e_next = h_rd;
                    best_next   = {cur_reg[SLOT_W-2:0], 1'b1};
                end
                state_next = ST_DN_STEP;
            end
            ST_DN_STEP:
            begin
                if (best_reg == cur_reg)
                    state_next = ST_DN_MOVE;
                else
                begin
                    // child moves up into cur
                    h_we       = 1'b1;
                    h_addr     = cur_reg;
                    h_wdata    = best_e_reg;
                    p_we       = 1'b1;
                    p_addr     = best_e_reg.id;
                    p_wdata    = cur_reg;
                    cur_next   = best_reg;
                    state_next = ST_DN_RDL;
                end
            end
            ST_DN_MOVE:
            begin
                // final home of the moving item
                h_we       = 1'b1;
                h_addr     = cur_reg;
                h_wdata    = cur_e_reg;
                p_we       = 1'b1;
                p_addr     = cur_e_reg.id;
                p_wdata    = cur_reg;
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    assign busy         = (state_reg != ST_IDLE);
    assign result_valid = res_reg;
    assign heap_empty   = emp_reg;
    assign top_id       = top_reg;

`ifndef SYNTHESIS
    a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= SLOT_W'(CAPACITY))
        else $error("heap count above capacity");
    a_res_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        res_reg |=> !res_reg)
        else $error("result strobe longer than one cycle");
    a_res_query: assert property (@(posedge clk) disable iff (!rst_n)
        res_reg |-> act_reg == ACT_QUERY)
        else $error("result for a non-query item");
    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_IDLE |=> count_reg == $past(count_reg))
        else $error("count changed while idle");
`endif

endmodule
